// File: hdl/x87fc_pkg.sv
// ----------------------------------------------------------------------------
// x87fc_pkg
// Types and constants shared by the extended-precision compare block.
// ----------------------------------------------------------------------------
`default_nettype none
package x87fc_pkg;

  localparam int unsigned ExpW = 15;
  localparam int unsigned SigW = 64;
  localparam logic [ExpW-1:0] ExpMax = 15'h7fff;

  typedef enum logic [2:0] {
    OP_FCOM    = 3'd0,
    OP_FCOMP   = 3'd1,
    OP_FCOMPP  = 3'd2,
    OP_FUCOM   = 3'd3,
    OP_FUCOMP  = 3'd4,
    OP_FUCOMPP = 3'd5,
    OP_FCOM_M  = 3'd6,
    OP_UNUSED  = 3'd7
  } opcode_t;

  localparam logic [2:0] CC_GREATER   = 3'd0;
  localparam logic [2:0] CC_LESS      = 3'd1;
  localparam logic [2:0] CC_EQUAL     = 3'd4;
  localparam logic [2:0] CC_UNORDERED = 3'd7;

  localparam logic [0:0] REG_INVALID_MASK  = 1'b0;
  localparam logic [0:0] REG_DENORMAL_MASK = 1'b1;

  typedef enum logic [2:0] {
    CL_ZERO, CL_DENORM, CL_NORMAL, CL_INF, CL_NAN
  } fclass_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  reg_index;
    logic [15:0] a_sign_exp;
    logic [63:0] a_mantissa;
    logic [15:0] b_sign_exp;
    logic [63:0] b_mantissa;
    logic        a_empty;
    logic        b_empty;
  } cmp_in_t;

  typedef struct packed {
    logic [2:0] cond_codes;
    logic       cc_write;
    logic       invalid_flag;
    logic       denormal_flag;
    logic       stack_fault;
    logic       illegal_op;
    logic [1:0] pop_count;
  } cmp_out_t;

endpackage
`default_nettype wire

// File: hdl/x87fc_stream_if.sv
// ----------------------------------------------------------------------------
// x87fc_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface x87fc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/x87_extended_float_compare.sv
// ----------------------------------------------------------------------------
// x87_extended_float_compare
// Executes one x87 compare (FCOM/FUCOM family) on two 80-bit operands.
//
// Channels: in_ch (sink) takes one x87fc_pkg::cmp_in_t per transfer; out_ch
// (source) gives one x87fc_pkg::cmp_out_t per transfer, in order.
// Configuration: cfg_we/cfg_index/cfg_data write the invalid and denormal
// mask bits (index 0 and 1); write them only while the block is empty.
// Throughput: one item per cycle unless the output stalls; the three register
// stages (classify, magnitude compare, result merge) each advance together.
// Stall: while out_ch.valid is high and out_ch.ready is low the whole pipeline
// holds and in_ch.ready drops with it, so nothing is lost or repeated; empty
// stages ahead of the output do not close up during the stall.
// Reset: clears all stage valid bits and sets both mask bits to 1.
// ----------------------------------------------------------------------------
`default_nettype none
module x87_extended_float_compare (
  input  wire logic clk,
  input  wire logic rst,
  x87fc_stream_if.sink   in_ch,
  x87fc_stream_if.source out_ch,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [0:0] cfg_data
);
  import x87fc_pkg::*;

  typedef struct packed {
    logic        ill;
    logic        fucom;
    logic [1:0]  pops;
    logic        sf;
    logic        asig, bsig;
    fclass_t     ac, bc;
    logic        as_, bs;
    logic [ExpW-1:0] ea, eb;
    logic [SigW-1:0] am, bm;
  } s1_t;

  typedef struct packed {
    logic        ill;
    logic        fucom;
    logic [1:0]  pops;
    logic        sf;
    logic        asig, bsig;
    fclass_t     ac, bc;
    logic        as_, bs;
    logic        exp_gt, exp_eq, sig_gt, sig_eq;
  } s2_t;

  logic inv_mask, den_mask;

  logic     v1, v2, v3;
  s1_t      s1;
  s2_t      s2;
  cmp_out_t s3;
  logic     adv;

  assign adv          = out_ch.ready || !v3;
  assign in_ch.ready  = adv;
  assign out_ch.valid = v3;
  assign out_ch.data  = s3;

  function automatic fclass_t classify(input logic [ExpW-1:0] ex,
                                       input logic [SigW-1:0] m,
                                       output logic sig);
    fclass_t c;
    sig = 1'b0;
    if (ex == '0) begin
      c = (m == '0) ? CL_ZERO : CL_DENORM;
    end else if (!m[SigW-1]) begin
      sig = 1'b1;
      c   = CL_NAN;
    end else if (ex == ExpMax) begin
      if (m[SigW-2:0] == '0) begin
        c = CL_INF;
      end else begin
        sig = !m[SigW-2];
        c   = CL_NAN;
      end
    end else begin
      c = CL_NORMAL;
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mask <= 1'b1;
      den_mask <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVALID_MASK:  inv_mask <= cfg_data[0];
        REG_DENORMAL_MASK: den_mask <= cfg_data[0];
        default: ;
      endcase
    end
  end

  s1_t s1_next;
  always_comb begin
    cmp_in_t   d;
    opcode_t   op;
    logic [ExpW-1:0] aex, bex;
    logic      asg, bsg;
    d   = in_ch.data;
    op  = opcode_t'(d.opcode);
    aex = d.a_sign_exp[ExpW-1:0];
    bex = d.b_sign_exp[ExpW-1:0];
    s1_next.ill   = (op == OP_UNUSED) ||
                    ((op == OP_FCOMPP || op == OP_FUCOMPP) && d.reg_index != 3'd1);
    s1_next.fucom = (op == OP_FUCOM || op == OP_FUCOMP || op == OP_FUCOMPP);
    case (op)
      OP_FCOMP, OP_FUCOMP:   s1_next.pops = 2'd1;
      OP_FCOMPP, OP_FUCOMPP: s1_next.pops = 2'd2;
      default:               s1_next.pops = 2'd0;
    endcase
    s1_next.sf   = d.a_empty || (d.b_empty && op != OP_FCOM_M);
    s1_next.ac   = classify(aex, d.a_mantissa, asg);
    s1_next.bc   = classify(bex, d.b_mantissa, bsg);
    s1_next.asig = asg;
    s1_next.bsig = bsg;
    s1_next.as_  = d.a_sign_exp[15];
    s1_next.bs   = d.b_sign_exp[15];
    s1_next.ea   = (aex == '0) ? ExpW'(1) : aex;
    s1_next.eb   = (bex == '0) ? ExpW'(1) : bex;
    s1_next.am   = d.a_mantissa;
    s1_next.bm   = d.b_mantissa;
  end

  cmp_out_t s3_next;
  always_comb begin
    logic inv, den, mag_gt, mag_eq;
    logic [2:0] cc;
    inv = 1'b0;
    den = 1'b0;
    cc  = CC_GREATER;
    mag_gt = s2.exp_gt || (s2.exp_eq && s2.sig_gt);
    mag_eq = s2.exp_eq && s2.sig_eq;
    if (s2.sf) begin
      cc  = CC_UNORDERED;
      inv = 1'b1;
    end else if (s2.ac == CL_NAN || s2.bc == CL_NAN) begin
      cc  = CC_UNORDERED;
      inv = s2.fucom ? (s2.asig || s2.bsig) : 1'b1;
    end else begin
      if (s2.ac == CL_ZERO && s2.bc == CL_ZERO) begin
        cc = CC_EQUAL;
      end else if (s2.as_ != s2.bs) begin
        cc = s2.as_ ? CC_LESS : CC_GREATER;
      end else if (mag_eq) begin
        cc = CC_EQUAL;
      end else begin
        cc = (mag_gt ^ s2.as_) ? CC_GREATER : CC_LESS;
      end
      den = (s2.ac == CL_DENORM) || (s2.bc == CL_DENORM);
    end
    s3_next.cond_codes    = s2.ill ? CC_GREATER : cc;
    s3_next.cc_write      = !s2.ill;
    s3_next.invalid_flag  = !s2.ill && inv;
    s3_next.denormal_flag = !s2.ill && den;
    s3_next.stack_fault   = !s2.ill && s2.sf;
    s3_next.illegal_op    = s2.ill;
    s3_next.pop_count     = (s2.ill || (inv && !inv_mask) || (den && !den_mask)) ?
                            2'd0 : s2.pops;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2.ill    <= s1.ill;
      s2.fucom  <= s1.fucom;
      s2.pops   <= s1.pops;
      s2.sf     <= s1.sf;
      s2.asig   <= s1.asig;
      s2.bsig   <= s1.bsig;
      s2.ac     <= s1.ac;
      s2.bc     <= s1.bc;
      s2.as_    <= s1.as_;
      s2.bs     <= s1.bs;
      s2.exp_gt <= s1.ea > s1.eb;
      s2.exp_eq <= s1.ea == s1.eb;
      s2.sig_gt <= s1.am > s1.bm;
      s2.sig_eq <= s1.am == s1.bm;
      s3 <= s3_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/x87fc_checker.sv
// ----------------------------------------------------------------------------
// x87fc_checker
// Port-level checks on the compare block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module x87fc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [2:0] cond_codes,
  input wire logic cc_write,
  input wire logic illegal_op,
  input wire logic stack_fault,
  input wire logic invalid_flag,
  input wire logic [1:0] pop_count
);
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready) else $error("input stalled needlessly");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cond_codes)))
    else $error("stalled output changed");

  a_illegal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && illegal_op) |-> (!cc_write && cond_codes == 3'd0 && pop_count == 2'd0))
    else $error("illegal encoding result wrong");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stack_fault) |-> (invalid_flag && cond_codes == 3'd7))
    else $error("stack fault result wrong");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 in_ready [*2] |=> out_valid)
    else $error("result missing");
endmodule

bind x87_extended_float_compare x87fc_checker u_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cond_codes(out_ch.data.cond_codes), .cc_write(out_ch.data.cc_write),
  .illegal_op(out_ch.data.illegal_op), .stack_fault(out_ch.data.stack_fault),
  .invalid_flag(out_ch.data.invalid_flag), .pop_count(out_ch.data.pop_count)
);
`default_nettype wire

// File: bench/tb_x87_extended_float_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x87_extended_float_compare
// Drives x87 compare instructions through the block with bursty input and a
// stalling output, predicts each outcome from the operand classes and the
// mask bits, and checks every output field in order.
// ----------------------------------------------------------------------------
module tb_x87_extended_float_compare;
  import x87fc_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandItems = 800;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [0:0] cfg_data = '0;

  x87fc_stream_if #(.payload_t(cmp_in_t))  in_ch ();
  x87fc_stream_if #(.payload_t(cmp_out_t)) out_ch ();

  x87_extended_float_compare dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic     inv_mask = 1'b1;
  logic     den_mask = 1'b1;
  cmp_out_t pending_cmp[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       long_hold = 1'b0;
  bit       done = 1'b0;

  typedef struct {
    cmp_in_t  item;
    bit       fixed;
    cmp_out_t want;
  } stim_row_t;

  function automatic fclass_t class_of(input logic [14:0] ex, input logic [63:0] m,
                                       output bit snan);
    snan = 1'b0;
    if (ex == '0) return (m == '0) ? CL_ZERO : CL_DENORM;
    if (!m[63]) begin
      snan = 1'b1;
      return CL_NAN;
    end
    if (ex == ExpMax) begin
      if (m[62:0] == '0) return CL_INF;
      snan = !m[62];
      return CL_NAN;
    end
    return CL_NORMAL;
  endfunction

  function automatic cmp_out_t compare_outcome(input cmp_in_t x);
    cmp_out_t r;
    fclass_t ca, cb;
    bit sa, sb, as, bs, fu;
    logic [14:0] ea, eb;
    int mag, res;
    r = '0;
    fu = x.opcode inside {OP_FUCOM, OP_FUCOMP, OP_FUCOMPP};
    if (x.opcode == OP_UNUSED ||
        ((x.opcode == OP_FCOMPP || x.opcode == OP_FUCOMPP) && x.reg_index != 3'd1)) begin
      r.illegal_op = 1'b1;
      return r;
    end
    r.cc_write = 1'b1;
    if (x.opcode == OP_FCOMP || x.opcode == OP_FUCOMP) r.pop_count = 2'd1;
    else if (x.opcode == OP_FCOMPP || x.opcode == OP_FUCOMPP) r.pop_count = 2'd2;
    if (x.a_empty || (x.b_empty && x.opcode != OP_FCOM_M)) begin
      r.cond_codes = CC_UNORDERED;
      r.invalid_flag = 1'b1;
      r.stack_fault = 1'b1;
    end else begin
      ca = class_of(x.a_sign_exp[14:0], x.a_mantissa, sa);
      cb = class_of(x.b_sign_exp[14:0], x.b_mantissa, sb);
      as = x.a_sign_exp[15];
      bs = x.b_sign_exp[15];
      if (ca == CL_NAN || cb == CL_NAN) begin
        r.cond_codes = CC_UNORDERED;
        r.invalid_flag = fu ? (sa || sb) : 1'b1;
      end else begin
        ea = (x.a_sign_exp[14:0] == '0) ? 15'd1 : x.a_sign_exp[14:0];
        eb = (x.b_sign_exp[14:0] == '0) ? 15'd1 : x.b_sign_exp[14:0];
        if (ea != eb) mag = (ea > eb) ? 1 : -1;
        else if (x.a_mantissa != x.b_mantissa) mag = (x.a_mantissa > x.b_mantissa) ? 1 : -1;
        else mag = 0;
        if (ca == CL_ZERO && cb == CL_ZERO) res = 0;
        else if (as != bs) res = as ? -1 : 1;
        else res = as ? -mag : mag;
        r.cond_codes = (res > 0) ? CC_GREATER : ((res < 0) ? CC_LESS : CC_EQUAL);
        r.denormal_flag = (ca == CL_DENORM || cb == CL_DENORM);
      end
    end
    if ((r.invalid_flag && !inv_mask) || (r.denormal_flag && !den_mask)) r.pop_count = '0;
    return r;
  endfunction

  function automatic logic [79:0] random_operand();
    logic [15:0] se;
    logic [63:0] m;
    se = 16'($urandom);
    m = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: se[14:0] = '0;
      1: begin
        se[14:0] = '0;
        m = '0;
      end
      2: begin
        se[14:0] = ExpMax;
        m = 64'h8000_0000_0000_0000;
      end
      3: begin
        se[14:0] = ExpMax;
        m[63] = 1'b1;
      end
      4: ;
      default: begin
        se[14:0] = 15'($urandom_range(16300, 16460));
        m[63] = 1'b1;
      end
    endcase
    return {se, m};
  endfunction

  function automatic cmp_in_t random_compare();
    cmp_in_t x;
    logic [79:0] a, b;
    x.opcode = 3'($urandom_range(0, 7));
    x.reg_index = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'd1;
    a = random_operand();
    b = ($urandom_range(0, 5) == 0) ? a : random_operand();
    if ($urandom_range(0, 3) == 0) b[79] = ~a[79];
    if ($urandom_range(0, 3) == 0) b[15:0] = a[15:0] + 16'($urandom_range(0, 2)) - 16'd1;
    {x.a_sign_exp, x.a_mantissa} = a;
    {x.b_sign_exp, x.b_mantissa} = b;
    x.a_empty = ($urandom_range(0, 15) == 0);
    x.b_empty = ($urandom_range(0, 15) == 0);
    return x;
  endfunction

  function automatic stim_row_t row(input opcode_t op, input logic [2:0] ri,
                                    input logic [79:0] a, input logic [79:0] b,
                                    input logic ae, input logic be, input bit fixed,
                                    input cmp_out_t want);
    stim_row_t s;
    s.item = {op, ri, a, b, ae, be};
    s.fixed = fixed;
    s.want = want;
    return s;
  endfunction

  task automatic send(input cmp_in_t x);
    in_ch.data <= x;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic write_mask(input logic [0:0] idx, input logic v);
    while (pending_cmp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_INVALID_MASK) inv_mask = v;
    else den_mask = v;
  endtask

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) pending_cmp.push_back(compare_outcome(in_ch.data));
  end

  always @(posedge clk) begin
    cmp_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_cmp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_ch.data);
        errors++;
      end else begin
        want = pending_cmp.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: expected %p actual %p", $time, want, out_ch.data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int hold;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
      for (hold = 0; hold < 40; hold++) @(posedge clk);
      long_hold = 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 7) < 5) || ($time / 4000) % 5 == 0;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_x87_extended_float_compare failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    cmp_out_t w;
    int burst;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    w = '0;
    w.illegal_op = 1'b1;
    rows.push_back(row(OP_FCOMPP, 3'd0, '0, '0, 1'b0, 1'b0, 1'b1, w));
    rows.push_back(row(OP_FUCOMPP, 3'd7, '0, '0, 1'b0, 1'b0, 1'b1, w));
    rows.push_back(row(OP_UNUSED, 3'd1, '0, '0, 1'b0, 1'b0, 1'b1, w));
    w = '0;
    w.cc_write = 1'b1;
    w.cond_codes = CC_UNORDERED;
    w.invalid_flag = 1'b1;
    w.stack_fault = 1'b1;
    w.pop_count = 2'd2;
    rows.push_back(row(OP_FCOMPP, 3'd1, '0, '0, 1'b1, 1'b0, 1'b1, w));
    w.pop_count = 2'd0;
    rows.push_back(row(OP_FCOM, 3'd3, '0, '0, 1'b0, 1'b1, 1'b1, w));
    rows.push_back(row(OP_FCOM_M, 3'd0, '0, '0, 1'b1, 1'b1, 1'b1, w));
    w = '0;
    w.cc_write = 1'b1;
    w.cond_codes = CC_EQUAL;
    rows.push_back(row(OP_FCOM_M, 3'd0, '0, 80'h8000_0000_0000_0000_0000,
                       1'b0, 1'b1, 1'b1, w));
    rows.push_back(row(OP_FUCOM, 3'd2, 80'h7fff_8000_0000_0000_0000,
                       80'h7fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOMP, 3'd1, 80'hffff_8000_0000_0000_0000,
                       80'h7fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FUCOMP, 3'd4, 80'h7fff_c000_0000_0000_0001,
                       80'h3fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FUCOMPP, 3'd1, 80'h7fff_8000_0000_0000_0001,
                       80'h3fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOM, 3'd5, 80'h7fff_c000_0000_0000_0000,
                       80'h0000_0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FUCOM, 3'd6, 80'h3fff_0000_0000_0000_0001,
                       80'h3fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FUCOM, 3'd6, 80'h7fff_7fff_ffff_ffff_ffff,
                       80'h3fff_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOM, 3'd1, 80'h0000_8000_0000_0000_0000,
                       80'h0001_8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOMP, 3'd7, 80'h8000_0000_0000_0000_0001,
                       80'h0000_ffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOM_M, 3'd0, 80'h7ffe_ffff_ffff_ffff_ffff,
                       80'hfffe_ffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOMPP, 3'd1, 80'hc000_8000_0000_0000_0000,
                       80'hc000_8000_0000_0000_0001, 1'b0, 1'b0, 1'b0, w));
    rows.push_back(row(OP_FCOM, 3'd0, 80'hffff_ffff_ffff_ffff_ffff,
                       80'h7fff_ffff_ffff_ffff_ffff, 1'b0, 1'b0, 1'b0, w));

    foreach (rows[k]) begin
      if (rows[k].fixed && compare_outcome(rows[k].item) !== rows[k].want) begin
        $display("%0t: expected %p actual %p", $time, rows[k].want,
                 compare_outcome(rows[k].item));
        errors++;
      end
      send(rows[k].item);
    end
    in_ch.valid <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      write_mask(REG_INVALID_MASK, phase[0]);
      write_mask(REG_DENORMAL_MASK, phase[1]);
      if (phase == 2) long_hold = 1'b1;
      for (int n = 0; n < RandItems / 4; ) begin
        burst = $urandom_range(1, 30);
        repeat (burst) begin
          send(random_compare());
          n++;
        end
        if ($urandom_range(0, 2) != 0) gap();
      end
      in_ch.valid <= 1'b0;
    end

    while (pending_cmp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb_x87_extended_float_compare passed");
    else $display("tb_x87_extended_float_compare failed");
    $finish;
  end
endmodule

// File: filelist.f
hdl/x87fc_pkg.sv
hdl/x87fc_stream_if.sv
hdl/x87_extended_float_compare.sv
hdl/x87fc_checker.sv
bench/tb_x87_extended_float_compare.sv
